// ----- hw/rtl/mcp_pkg.sv -----
package mcp_pkg;

    localparam int unsigned COUNTERS_DEFAULT = 8;
    localparam int unsigned SLOT_LIMIT = 8;

    localparam int unsigned OP_W = 3;
    localparam int unsigned SLOT_W = 3;
    localparam int unsigned COUNT_W = 32;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam op_t OP_TICK = 3'd0;
    localparam op_t OP_ALLOC = 3'd1;
    localparam op_t OP_RELEASE = 3'd2;
    localparam op_t OP_RESTART = 3'd3;
    localparam op_t OP_QUERY = 3'd4;

    localparam count_t COUNT_MAX = '1;

endpackage

// ----- hw/rtl/ms_counter_pool_top.sv -----
// Tick: the result word is registered in the cycle after acceptance, and the walk over
// the count memory holds off the next word until all min(COUNTERS, 8) slots are done,
// one slot per cycle through the one read port and the one write port of the memory.
// Query: the memory read is registered, then the result in the query state. Other ops
// register theirs in the cycle after acceptance. Reset clears the in-use flags and the
// control state, not the count memory: an unused slot reads as zero by its in-use flag.
module ms_counter_pool_top #(
    parameter int unsigned COUNTERS = mcp_pkg::COUNTERS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  mcp_pkg::op_t   op,
    input  mcp_pkg::slot_t slot,
    input  logic           handle_valid,
    input  mcp_pkg::count_t threshold,
    output logic           result_valid,
    input  logic           result_stall,
    output mcp_pkg::slot_t granted_slot,
    output logic           grant_ok,
    output logic           elapsed,
    output mcp_pkg::count_t count_value
);
    import mcp_pkg::*;

    localparam int unsigned USABLE = (COUNTERS < SLOT_LIMIT) ? COUNTERS : SLOT_LIMIT;
    localparam int unsigned IDX_W = (USABLE > 1) ? $clog2(USABLE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USABLE - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_QUERY
    } state_t;

    state_t state_reg, state_next;
    logic result_valid_reg, result_valid_next;
    slot_t granted_slot_reg, granted_slot_next;
    logic grant_ok_reg, grant_ok_next;
    logic elapsed_reg, elapsed_next;
    count_t count_value_reg, count_value_next;
    logic [USABLE-1:0] in_use_reg, in_use_next;
    logic [IDX_W-1:0] tick_idx_reg, tick_idx_next;
    count_t thr_reg, thr_next;
    logic q_addr_reg, q_addr_next;
    logic [IDX_W-1:0] q_idx_reg, q_idx_next;

    count_t count_mem [USABLE];
    count_t mem_rdata_reg;
    logic mem_we;
    logic mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    count_t mem_wdata;

    logic accept;
    logic addressed;
    logic [IDX_W-1:0] slot_idx;
    logic free_found;
    logic [IDX_W-1:0] free_idx;
    count_t q_count;

    assign item_stall = !(state_reg == S_IDLE && (!result_valid_reg || !result_stall));
    assign accept = item_valid && !item_stall;
    assign addressed = handle_valid && (32'(slot) < USABLE);
    assign slot_idx = slot[IDX_W-1:0];
    assign q_count = in_use_reg[q_idx_reg] ? mem_rdata_reg : '0;

    assign result_valid = result_valid_reg;
    assign granted_slot = granted_slot_reg;
    assign grant_ok = grant_ok_reg;
    assign elapsed = elapsed_reg;
    assign count_value = count_value_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = int'(USABLE) - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        mem_wdata = '0;
        if (state_reg == S_TICK)
        begin
            mem_we = in_use_reg[tick_idx_reg] && (mem_rdata_reg != COUNT_MAX);
            mem_waddr = tick_idx_reg;
            mem_wdata = mem_rdata_reg + 1'b1;
            if (tick_idx_reg != LAST_IDX)
            begin
                mem_re = 1'b1;
                mem_raddr = tick_idx_reg + 1'b1;
            end
        end
        else if (accept)
        begin
            unique case (op)
                OP_TICK:
                begin
                    mem_re = 1'b1;
                end
                OP_ALLOC:
                begin
                    mem_we = free_found;
                    mem_waddr = free_idx;
                end
                OP_RESTART:
                begin
                    mem_we = addressed;
                    mem_waddr = slot_idx;
                end
                OP_QUERY:
                begin
                    mem_re = 1'b1;
                    mem_raddr = slot_idx;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= count_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        result_valid_next = result_valid_reg;
        granted_slot_next = granted_slot_reg;
        grant_ok_next = grant_ok_reg;
        elapsed_next = elapsed_reg;
        count_value_next = count_value_reg;
        in_use_next = in_use_reg;
        tick_idx_next = tick_idx_reg;
        thr_next = thr_reg;
        q_addr_next = q_addr_reg;
        q_idx_next = q_idx_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_valid_next = 1'b1;
                    granted_slot_next = '0;
                    grant_ok_next = 1'b0;
                    elapsed_next = 1'b0;
                    count_value_next = '0;
                    unique case (op)
                        OP_TICK:
                        begin
                            tick_idx_next = '0;
                            state_next = S_TICK;
                        end
                        OP_ALLOC:
                        begin
                            if (free_found)
                            begin
                                in_use_next[free_idx] = 1'b1;
                                granted_slot_next = SLOT_W'(free_idx);
                                grant_ok_next = 1'b1;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (addressed)
                            begin
                                in_use_next[slot_idx] = 1'b0;
                            end
                        end
                        OP_QUERY:
                        begin
                            result_valid_next = 1'b0;
                            thr_next = threshold;
                            q_addr_next = addressed;
                            q_idx_next = slot_idx;
                            state_next = S_QUERY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (tick_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    tick_idx_next = tick_idx_reg + 1'b1;
                end
            end
            S_QUERY:
            begin
                result_valid_next = 1'b1;
                elapsed_next = !q_addr_reg || (q_count >= thr_reg);
                count_value_next = q_addr_reg ? q_count : '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            result_valid_reg <= 1'b0;
            granted_slot_reg <= '0;
            grant_ok_reg <= 1'b0;
            elapsed_reg <= 1'b0;
            count_value_reg <= '0;
            in_use_reg <= '0;
            tick_idx_reg <= '0;
            thr_reg <= '0;
            q_addr_reg <= 1'b0;
            q_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
            granted_slot_reg <= granted_slot_next;
            grant_ok_reg <= grant_ok_next;
            elapsed_reg <= elapsed_next;
            count_value_reg <= count_value_next;
            in_use_reg <= in_use_next;
            tick_idx_reg <= tick_idx_next;
            thr_reg <= thr_next;
            q_addr_reg <= q_addr_next;
            q_idx_reg <= q_idx_next;
        end
    end

endmodule

// ----- hw/rtl/mcp_check.sv -----
module mcp_check (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input mcp_pkg::op_t    op,
    input mcp_pkg::slot_t  slot,
    input logic            handle_valid,
    input mcp_pkg::count_t threshold,
    input logic            result_valid,
    input logic            result_stall,
    input mcp_pkg::slot_t  granted_slot,
    input logic            grant_ok,
    input logic            elapsed,
    input mcp_pkg::count_t count_value
);
    import mcp_pkg::*;

    a_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(op) && $stable(slot)
            && $stable(handle_valid) && $stable(threshold))
        else $error("stalled input word changed");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(granted_slot)
            && $stable(grant_ok) && $stable(elapsed) && $stable(count_value))
        else $error("stalled result word changed");

    a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && grant_ok |-> !elapsed && count_value == '0)
        else $error("grant word carries query fields");

    a_no_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !grant_ok |-> granted_slot == '0)
        else $error("slot reported without a grant");

    a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && op == OP_TICK |=> item_stall)
        else $error("word accepted during the tick walk");

endmodule

bind ms_counter_pool_top mcp_check u_mcp_check (.*);
